@@ hdl/sss_pkg.sv @@
`timescale 1ns / 1ps

package sss_pkg;

  localparam int NEEDLE_MAX = 16;
  localparam int WIN_DEPTH  = NEEDLE_MAX - 1;
  localparam int LEN_W      = 5;
  localparam int AGE_W      = 4;
  localparam int POS_W      = 16;
  localparam int HAY_MAX    = 65536;
  localparam int POS_LAST   = HAY_MAX - 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CASE_INSENSITIVE = CFG_IDX_W'(3);

  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CHAR_A   = 8'h61;
  localparam logic [7:0] CHAR_Z   = 8'h7a;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] hay_byte;
    logic       first_byte;
    logic       last_byte;
  } sss_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } sss_out_t;

  typedef struct packed {
    logic [NEEDLE_MAX-1:0][7:0] needle;
    logic [LEN_W-1:0]           eff_len;
    logic                       fold;
  } sss_cfg_t;

  // Exact compare, or ASCII letter compare when folding.
  function automatic logic byte_agree(logic [7:0] a, logic [7:0] b, logic fold);
    logic [7:0] la;
    logic [7:0] lb;
    la = a | CASE_BIT;
    lb = b | CASE_BIT;
    return (a == b) ||
           (fold && (la == lb) && (la >= CHAR_A) && (la <= CHAR_Z));
  endfunction

endpackage

@@ hdl/sss_cfg.sv @@
`timescale 1ns / 1ps

module sss_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sss_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output sss_pkg::sss_cfg_t                cfg_o
);

  logic [sss_pkg::CFG_DATA_W-1:0] needle_low_q;
  logic [sss_pkg::CFG_DATA_W-1:0] needle_high_q;
  logic [sss_pkg::LEN_W-1:0]      needle_len_q;
  logic                           fold_q;

  logic [sss_pkg::NEEDLE_MAX-1:0][7:0] needle;
  logic [sss_pkg::LEN_W-1:0]           cap;
  logic [sss_pkg::LEN_W-1:0]           eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q  <= '0;
      needle_high_q <= '0;
      needle_len_q  <= '0;
      fold_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sss_pkg::REG_NEEDLE_LOW:       needle_low_q  <= cfg_data_i;
        sss_pkg::REG_NEEDLE_HIGH:      needle_high_q <= cfg_data_i;
        sss_pkg::REG_NEEDLE_LENGTH:    needle_len_q  <= cfg_data_i[sss_pkg::LEN_W-1:0];
        sss_pkg::REG_CASE_INSENSITIVE: fold_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign needle = {needle_high_q, needle_low_q};

  // Needle length is capped at NEEDLE_MAX and stops at its first NUL within it.
  always_comb begin
    if (needle_len_q > sss_pkg::LEN_W'(sss_pkg::NEEDLE_MAX)) begin
      cap = sss_pkg::LEN_W'(sss_pkg::NEEDLE_MAX);
    end else begin
      cap = needle_len_q;
    end
    eff_len = cap;
    for (int j = sss_pkg::NEEDLE_MAX - 1; j >= 0; j--) begin
      if ((sss_pkg::LEN_W'(j) < cap) && (needle[j] == sss_pkg::CHAR_NUL)) begin
        eff_len = sss_pkg::LEN_W'(j);
      end
    end
  end

  assign cfg_o.needle  = needle;
  assign cfg_o.eff_len = eff_len;
  assign cfg_o.fold    = fold_q;

endmodule

@@ hdl/sss_match.sv @@
`timescale 1ns / 1ps

module sss_match (
  input  logic [7:0]                        cur_i,
  input  logic [sss_pkg::WIN_DEPTH-1:0][7:0] hist_i,
  input  sss_pkg::sss_cfg_t                 cfg_i,
  output logic                              hit_o
);

  logic [sss_pkg::NEEDLE_MAX-1:0][7:0] age_b;
  logic [sss_pkg::NEEDLE_MAX-1:0]      hit_len;
  logic [sss_pkg::AGE_W-1:0]           sel;

  // age 0 is the current byte, age a is window entry a-1
  assign age_b = {hist_i, cur_i};

  // Candidate for needle length L: needle byte j lines up with age L-1-j.
  always_comb begin
    for (int l = 0; l < sss_pkg::NEEDLE_MAX; l++) begin
      hit_len[l] = 1'b1;
      for (int j = 0; j <= l; j++) begin
        if (!sss_pkg::byte_agree(age_b[l-j], cfg_i.needle[j], cfg_i.fold)) begin
          hit_len[l] = 1'b0;
        end
      end
    end
  end

  assign sel   = sss_pkg::AGE_W'(cfg_i.eff_len - sss_pkg::LEN_W'(1));
  assign hit_o = hit_len[sel];

endmodule

@@ hdl/substring_search_stream_unit.sv @@
`timescale 1ns / 1ps

// Streaming first-occurrence substring search. Haystack bytes come in one
// word per cycle on the input channel unless it stalls; the user must set
// the needle (up to 16 bytes, optional ASCII case folding) through the
// config port while the block is idle: the block does not enforce this.
// Every haystack, opened by a word with first_byte set, gives at most one
// result word: found with the match start offset on the byte that completes
// the match, or not found on a NUL byte, on last_byte, or at offset 65535.
// A haystack cut short by the next first_byte gives none. Bytes after the
// result are dropped until the next first_byte. Throughput is one byte per
// cycle unless the output stalls: the whole window compare and the
// window/position update are combinational between the input register and
// the result register, so consecutive bytes chain through one state update.
// The input register stages a byte and the result register its result word.
// A stalled result holds the staged byte; input stalls until output drains.

module substring_search_stream_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sss_pkg::sss_in_t               in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sss_pkg::sss_out_t              out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sss_pkg::sss_cfg_t cfg;

  // input register
  logic             in_valid_q;
  sss_pkg::sss_in_t in_word_q;

  // search state
  logic [sss_pkg::WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [sss_pkg::POS_W-1:0]          pos_q, pos_d;
  logic                               done_q, done_d;

  // result register
  logic              out_valid_q;
  sss_pkg::sss_out_t out_word_q;

  logic                               out_free;
  logic                               proc_go;
  logic                               in_accept;
  logic [sss_pkg::WIN_DEPTH-1:0][7:0] hist;
  logic [sss_pkg::POS_W-1:0]          pos_eff;
  logic                               done_eff;
  logic                               win_hit;
  logic                               pos_ok;
  logic                               res_valid;
  sss_pkg::sss_out_t                  res;

  assign cfg_ready_o = 1'b1;

  sss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the staged byte moves on whenever the result register can
  // take a word this cycle (empty, or being drained).
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_go    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // first_byte restarts the search before this byte is looked at.
  assign hist     = in_word_q.first_byte ? '0 : win_q;
  assign pos_eff  = in_word_q.first_byte ? '0 : pos_q;
  assign done_eff = in_word_q.first_byte ? 1'b0 : done_q;

  sss_match u_match (
    .cur_i  (in_word_q.hay_byte),
    .hist_i (hist),
    .cfg_i  (cfg),
    .hit_o  (win_hit)
  );

  // enough bytes seen to hold the whole needle
  assign pos_ok = ({1'b0, pos_eff} + (sss_pkg::POS_W + 1)'(1)) >=
                  (sss_pkg::POS_W + 1)'(cfg.eff_len);

  always_comb begin
    res_valid          = 1'b0;
    res.found          = 1'b0;
    res.match_position = '0;
    done_d             = done_eff;
    pos_d              = pos_eff;
    win_d              = {hist[sss_pkg::WIN_DEPTH-2:0], in_word_q.hay_byte};
    if (!done_eff) begin
      if (cfg.eff_len == '0) begin
        // empty needle matches at offset zero on any byte
        res_valid = 1'b1;
        res.found = 1'b1;
        done_d    = 1'b1;
      end else if (in_word_q.hay_byte == sss_pkg::CHAR_NUL) begin
        res_valid = 1'b1;
        done_d    = 1'b1;
      end else if (pos_ok && win_hit) begin
        res_valid          = 1'b1;
        res.found          = 1'b1;
        res.match_position = pos_eff -
                             sss_pkg::POS_W'(cfg.eff_len - sss_pkg::LEN_W'(1));
        done_d             = 1'b1;
      end else if (in_word_q.last_byte ||
                   (pos_eff == sss_pkg::POS_W'(sss_pkg::POS_LAST))) begin
        res_valid = 1'b1;
        done_d    = 1'b1;
      end else begin
        pos_d = pos_eff + sss_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b1;
      pos_q       <= '0;
      win_q       <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (proc_go) begin
        in_valid_q <= 1'b0;
      end
      if (proc_go) begin
        done_q <= done_d;
        pos_q  <= pos_d;
        win_q  <= win_d;
      end
      if (proc_go && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
    if (proc_go && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a result always closes the search
  a_result_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && res_valid |=> done_q)
    else $error("search still open after a result word");

  // with nothing staged the search state cannot reopen
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !in_valid_q |=> done_q)
    else $error("search reopened without a byte");

  // a match never starts after the byte that completes it
  a_match_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && res_valid && res.found |-> res.match_position <= pos_eff)
    else $error("match start beyond current position");

endmodule

@@ tb/substring_search_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, result and config channels, keeps its own copy of the
// search state and compares every result word with the oldest one predicted.
module substring_search_checker import sss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  sss_in_t               in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  sss_out_t              out_word_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    error_count_o,
  output int                    pending_o,
  output int                    live_words_o
);

  logic [NEEDLE_MAX-1:0][7:0] needle_q;
  logic [LEN_W-1:0]           len_q;
  logic                       fold_q;
  logic [7:0]                 hist_q [WIN_DEPTH];
  int unsigned                pos_q;
  logic                       idle_q;
  sss_out_t                   awaited_results [$];

  // Letters go to lower case, everything else stays.
  function automatic logic [7:0] lower_letter(logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    return (lc >= CHAR_A && lc <= CHAR_Z) ? lc : c;
  endfunction

  function automatic logic same_char(logic [7:0] a, logic [7:0] b, logic fold);
    return (a == b) || (fold && lower_letter(a) == lower_letter(b));
  endfunction

  // Needle length in use: capped at NEEDLE_MAX, cut at the first NUL.
  function automatic int needle_span();
    int cap;
    cap = (int'(len_q) > NEEDLE_MAX) ? NEEDLE_MAX : int'(len_q);
    for (int j = 0; j < cap; j++)
      if (needle_q[j] == CHAR_NUL) return j;
    return cap;
  endfunction

  // Advances the search by one word; returns 1 when it yields a result.
  function automatic logic scan_byte(sss_in_t w, output sss_out_t res);
    int   span;
    logic hit;
    res = '0;
    if (w.first_byte) begin
      idle_q = 1'b0;
      pos_q  = 0;
      foreach (hist_q[k]) hist_q[k] = '0;
    end
    if (idle_q) return 1'b0;
    span = needle_span();
    if (span == 0) begin
      idle_q    = 1'b1;
      res.found = 1'b1;
      return 1'b1;
    end
    if (w.hay_byte == CHAR_NUL) begin
      idle_q = 1'b1;
      return 1'b1;
    end
    hit = (pos_q + 1 >= span);
    if (hit) begin
      hit = same_char(w.hay_byte, needle_q[span-1], fold_q);
      for (int j = 0; j < span - 1; j++)
        if (!same_char(hist_q[span-2-j], needle_q[j], fold_q)) hit = 1'b0;
    end
    for (int k = WIN_DEPTH - 1; k > 0; k--) hist_q[k] = hist_q[k-1];
    hist_q[0] = w.hay_byte;
    if (hit) begin
      idle_q             = 1'b1;
      res.found          = 1'b1;
      res.match_position = POS_W'(pos_q + 1 - span);
      return 1'b1;
    end
    if (w.last_byte || pos_q == POS_LAST) begin
      idle_q = 1'b1;
      return 1'b1;
    end
    pos_q++;
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin
    sss_out_t want;
    sss_out_t got;
    if (!rst_ni) begin
      needle_q = '0;
      len_q    = '0;
      fold_q   = 1'b0;
      foreach (hist_q[k]) hist_q[k] = '0;
      pos_q    = 0;
      idle_q   = 1'b1;
      awaited_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_word_i;
        if (awaited_results.size() == 0) begin
          $error("found/match_position: nothing expected, got %0d/%0d",
                 got.found, got.match_position);
          error_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            error_count_o++;
          end
          if (got.match_position !== want.match_position) begin
            $error("match_position: expected %0d, got %0d",
                   want.match_position, got.match_position);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.first_byte || !idle_q) live_words_o++;
        if (scan_byte(in_word_i, want)) awaited_results.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_NEEDLE_LOW:       needle_q[7:0]  = cfg_data_i;
          REG_NEEDLE_HIGH:      needle_q[15:8] = cfg_data_i;
          REG_NEEDLE_LENGTH:    len_q          = cfg_data_i[LEN_W-1:0];
          REG_CASE_INSENSITIVE: fold_q         = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the streaming substring search. The checker
// beside the block does all prediction; this module only feeds words,
// writes the needle registers while the block is quiet and decides the end.
module tb_top;
  import sss_pkg::*;

  localparam int WORD_GOAL     = 1250;    // random words that reach the search
  localparam int CYCLE_LIMIT   = 200000;  // several times a slow random run
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;       // lets the pipeline empty after the last result

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  sss_in_t               in_word   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  sss_out_t              out_word;
  logic                  cfg_ready;

  int error_count;
  int pending;
  int live_words;

  // Sender pacing: bursts of words, then a gap; gap_max of zero means no idling.
  int burst_left = 0;
  int gap_max    = 0;

  // Receiver pattern and the long hold-off handshake.
  int hold_req   = 0;
  int hold_ack   = 0;
  int hold_left  = 0;
  int stall_mode = 0;
  int mode_left  = 0;

  // Copy of the active needle, used only to plant matches in the haystacks.
  logic [127:0] plant_bytes = '0;
  int           plant_len   = 0;

  always #5 clk_i = ~clk_i;

  substring_search_stream_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  substring_search_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending),
    .live_words_o  (live_words)
  );

  // Receiver: switches between stall patterns at random intervals.
  // A hold request from the stimulus side forces a long unbroken stall.
  always @(posedge clk_i) begin
    logic stall_now;
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       stall_now = 1'b0;                        // never stall
      1:       stall_now = ($urandom_range(0, 7) == 0); // light
      2:       stall_now = 1'($urandom_range(0, 1));    // half
      3:       stall_now = ($urandom_range(0, 3) != 0); // heavy
      default: stall_now = !out_stall;                  // alternating
    endcase
    if (hold_left > 0) begin
      stall_now = 1'b1;
      hold_left--;
    end
    out_stall <= stall_now;
  end

  // Offers one word and returns at the edge where it is taken.
  // Valid stays high into the next call unless a gap starts there.
  task automatic send_word(input logic [7:0] b, input logic first, input logic last);
    int gap;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(gap_max, 4 * gap_max)
                                          : $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_word  <= '{hay_byte: b, first_byte: first, last_byte: last};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_text(input string s, input logic open_it, input logic close_it);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], open_it && i == 0, close_it && i == s.len() - 1);
  endtask

  // Stops offering, waits for every predicted result, then lets the
  // pipeline empty of words that give none.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains, then writes all four registers; unused data bits carry random noise.
  // A haystack left open stays open, so the next word sees the new needle.
  task automatic load_needle(input logic [127:0] bytes, input int len, input logic fold);
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] fold_word;
    int cap;
    drain();
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), {$urandom(), $urandom()});
    len_word  = {$urandom(), $urandom()};
    len_word[LEN_W-1:0] = LEN_W'(len);
    fold_word = {$urandom(), $urandom()};
    fold_word[0] = fold;
    write_reg(REG_NEEDLE_LOW, bytes[63:0]);
    write_reg(REG_NEEDLE_HIGH, bytes[127:64]);
    write_reg(REG_NEEDLE_LENGTH, len_word);
    write_reg(REG_CASE_INSENSITIVE, fold_word);
    plant_bytes = bytes;
    cap = (len > NEEDLE_MAX) ? NEEDLE_MAX : len;
    plant_len = cap;
    for (int j = cap - 1; j >= 0; j--)
      if (bytes[8*j +: 8] == CHAR_NUL) plant_len = j;
  endtask

  function automatic logic [127:0] text_bytes(input string s);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 16; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // Flips the case of a letter half the time.
  function automatic logic [7:0] mix_case(input logic [7:0] b);
    logic [7:0] lc;
    lc = b | CASE_BIT;
    if (lc >= CHAR_A && lc <= CHAR_Z && $urandom_range(0, 1)) return b ^ CASE_BIT;
    return b;
  endfunction

  // Mostly letters, some arbitrary bytes; the length picks the corner
  // cases: empty, full, above the maximum, or cut short by a NUL.
  task automatic random_needle();
    logic [127:0] nb;
    logic [7:0]   b;
    int           len;
    int           pick;
    for (int i = 0; i < 16; i++) begin
      b = CHAR_A + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) b = b ^ CASE_BIT;
      if ($urandom_range(0, 5) == 0) b = 8'($urandom_range(1, 255));
      nb[8*i +: 8] = b;
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0:       len = 0;
      1:       len = 16;
      2:       len = $urandom_range(17, 31);
      3: begin
        len = $urandom_range(2, 16);
        nb[8*$urandom_range(0, len - 1) +: 8] = CHAR_NUL;
      end
      default: len = $urandom_range(1, 6);
    endcase
    load_needle(nb, len, 1'($urandom_range(0, 1)));
  endtask

  // One haystack, built from needle bytes and noise, often with the needle
  // planted (case mixed, sometimes damaged). Ends on last_byte, on NUL, or
  // is left open for the next first byte to cut off.
  task automatic random_haystack();
    int         n;
    int         at;
    int         ending;
    int         r;
    logic [7:0] b;
    n  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 20);
    at = -1;
    if (plant_len > 0 && $urandom_range(0, 2) != 0) begin
      if (n < plant_len) n = plant_len + $urandom_range(0, 4);
      at = $urandom_range(0, n - plant_len);
    end
    ending = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (at >= 0 && i >= at && i < at + plant_len) begin
        b = mix_case(plant_bytes[8*(i-at) +: 8]);
        if ($urandom_range(0, 19) == 0) b = b ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        r = $urandom_range(0, 39);
        if (r == 0)
          b = CHAR_NUL;
        else if (r < 8 || plant_len == 0)
          b = 8'($urandom_range(1, 255));
        else
          b = mix_case(plant_bytes[8*$urandom_range(0, plant_len - 1) +: 8]);
      end
      send_word(b, i == 0, (ending == 0 || ending == 3) && i == n - 1);
    end
    if (ending == 1) send_word(CHAR_NUL, 1'b0, 1'b0);
    if (ending == 3)  // trailing words after the end are dropped
      repeat ($urandom_range(1, 4))
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[substring_search_stream_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int goal;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, no idling on the sender side.
    send_word("q", 1'b0, 1'b0);           // idle after reset: dropped
    send_word("q", 1'b1, 1'b0);           // empty needle: found at 0
    load_needle(text_bytes("aB"), 2, 1'b0);
    send_text("xaBy", 1'b1, 1'b0);        // found at 1, 'y' dropped
    send_text("Ab", 1'b1, 1'b1);          // exact compare: ends on last byte
    load_needle(text_bytes("a@"), 2, 1'b1);
    send_word("A", 1'b1, 1'b0);
    send_word(8'h60, 1'b0, 1'b1);         // '@' vs '`' do not fold
    send_text("A@", 1'b1, 1'b1);          // match on the last byte wins
    send_word("x", 1'b1, 1'b0);
    send_word(CHAR_NUL, 1'b0, 1'b0);      // NUL ends the string
    send_word(CHAR_NUL, 1'b1, 1'b1);      // NUL as first word, with last
    load_needle(128'h51_00_5a, 3, 1'b0);  // NUL inside cuts needle to "Z"
    send_text("yZ", 1'b1, 1'b0);
    load_needle('1, 31, 1'b1);            // length above max counts as 16
    for (int i = 0; i < 16; i++) send_word(8'hff, i == 0, 1'b0);

    // Needle changed while a haystack is open: new needle vs old window.
    load_needle(text_bytes("abc"), 3, 1'b0);
    send_text("zab", 1'b1, 1'b0);
    load_needle(text_bytes("bc"), 2, 1'b0);
    send_word("c", 1'b0, 1'b0);           // found at 2
    send_text("zz", 1'b1, 1'b0);
    load_needle(text_bytes("bc"), 0, 1'b0);
    send_word("k", 1'b0, 1'b0);           // emptied needle: found at 0

    // Receiver holds off while one-word haystacks keep coming, so results
    // back up into the block and the input stalls.
    load_needle(text_bytes("k"), 1, 1'b0);
    hold_req <= hold_req + 1;
    repeat (40) send_word("k", 1'b1, 1'b0);
    drain();

    // Random part: a new needle per phase, then a batch of haystacks.
    goal = live_words + WORD_GOAL;
    while (live_words < goal) begin
      random_needle();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 5) == 0) hold_req <= hold_req + 1;
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 7) == 0)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        random_haystack();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending == 0)
      $display("[substring_search_stream_unit] OK");
    else
      $display("[substring_search_stream_unit] ERROR");
    $finish;
  end

endmodule

@@ substring_search_stream_unit.f @@
hdl/sss_pkg.sv
hdl/sss_cfg.sv
hdl/sss_match.sv
hdl/substring_search_stream_unit.sv
tb/substring_search_checker.sv
tb/tb_top.sv
